### hw/rtl/salsa_pkg.sv
// ----------------------------------------------------------------------------
// salsa_pkg
// Shared types and fixed constants of the Salsa20 byte-stream cipher.
// ----------------------------------------------------------------------------
package salsa_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 64;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_KEY_0_7   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KEY_8_15  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY_16_23 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_24_31 = 3'd3;
  localparam logic [CFG_AW-1:0] REG_NONCE     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_KEY_MODE  = 3'd5;

  // diagonal constants ("expand 32-byte k" / "expand 16-byte k")
  localparam word_t CONST_EXPA = 32'h6170_7865;
  localparam word_t CONST_TE_K = 32'h6b20_6574;
  localparam word_t SIGMA_1    = 32'h3320_646e;
  localparam word_t SIGMA_2    = 32'h7962_2d32;
  localparam word_t TAU_1      = 32'h3120_646e;
  localparam word_t TAU_2      = 32'h7962_2d36;

  // quarter-round rotate amounts
  localparam int unsigned ROT_0 = 7;
  localparam int unsigned ROT_1 = 9;
  localparam int unsigned ROT_2 = 13;
  localparam int unsigned ROT_3 = 18;

  function automatic word_t rotl32(input word_t v, input int unsigned n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

### hw/rtl/salsa20_stream_cipher.sv
// ----------------------------------------------------------------------------
// salsa20_stream_cipher
// Byte-wide Salsa20 keystream XOR with one shared add-rotate-xor unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one message byte per word (in_tdata), in_tlast ends a message.
//   out_* : the byte XORed with the keystream, out_tlast copied through.
//   cfg_* : key words, nonce and key_mode, written while the block is idle.
// Timing:
//   A byte inside a 64-byte block is accepted and shows on out_* the next
//   cycle, one byte per cycle while the receiver takes them. A byte at a
//   64-byte boundary first builds a fresh keystream block: quarter-round
//   steps on the single 32-bit adder (one add-rotate-xor a cycle), then
//   feed-forward adds on the same adder; its result byte is registered
//   together with the last feed-forward add.
//   in_tready is low while a block is built and while the output register
//   is full and not being taken, so a stalled receiver holds one byte.
// Reset:
//   Position returns to zero, key_mode to the 32-byte key, key, nonce and
//   sequencer registers to zero; the output register empties.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher #(
  parameter int ROUND_COUNT = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [salsa_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [salsa_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] data_out
  output logic                          out_tlast
);

  localparam int RC_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RC_W-1:0] LAST_RND = RC_W'(ROUND_COUNT - 1);
  localparam bit ODD_ROUNDS = (ROUND_COUNT % 2) == 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  localparam logic [1:0] STEP_LAST = 2'd3;
  localparam logic [1:0] QUAD_LAST = 2'd3;
  localparam logic [3:0] ADD_LAST  = 4'd15;

  // configuration
  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_r;
  logic        mode_r;

  // sequencer and datapath
  logic [1:0]       st_r, st_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [1:0]       quad_r, quad_nxt;
  logic [RC_W-1:0]  rnd_r, rnd_nxt;
  logic [3:0]       add_r, add_nxt;
  logic [31:0]      pos_r, pos_nxt;
  salsa_pkg::word_t x_r [16];
  salsa_pkg::word_t x_nxt [16];
  salsa_pkg::byte_t byte_r;
  logic             last_r;
  logic             out_valid_r, out_valid_nxt;
  salsa_pkg::byte_t out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  salsa_pkg::word_t init_w [16];
  salsa_pkg::word_t y_w [16];
  salsa_pkg::word_t s5_w [16];
  salsa_pkg::word_t s1_w [16];
  salsa_pkg::word_t tp_w [16];
  salsa_pkg::word_t op_a, op_b, sum_w, rot_w, ks_word;
  salsa_pkg::byte_t ks_byte;
  logic [63:0]      hi0_w, hi1_w;

  logic accept, blk_start, emit_now, emit_blk, emit, last_rnd, do_tr;

  assign in_tready  = (st_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign blk_start  = accept && (pos_r[5:0] == 6'd0);
  assign emit_now   = accept && !blk_start;
  assign emit_blk   = (st_r == ST_ADD) && (add_r == ADD_LAST);
  assign emit       = emit_now || emit_blk;
  assign last_rnd   = (rnd_r == LAST_RND);
  // an odd round count ends on a column round: leave it untransposed
  assign do_tr      = !(last_rnd && ODD_ROUNDS);

  // block input words
  always_comb begin
    hi0_w      = mode_r ? key2_r : key0_r;
    hi1_w      = mode_r ? key3_r : key1_r;
    init_w[0]  = salsa_pkg::CONST_EXPA;
    init_w[1]  = key0_r[31:0];
    init_w[2]  = key0_r[63:32];
    init_w[3]  = key1_r[31:0];
    init_w[4]  = key1_r[63:32];
    init_w[5]  = mode_r ? salsa_pkg::SIGMA_1 : salsa_pkg::TAU_1;
    init_w[6]  = nonce_r[31:0];
    init_w[7]  = nonce_r[63:32];
    init_w[8]  = {6'd0, pos_r[31:6]};
    init_w[9]  = 32'd0;
    init_w[10] = mode_r ? salsa_pkg::SIGMA_2 : salsa_pkg::TAU_2;
    init_w[11] = hi0_w[31:0];
    init_w[12] = hi0_w[63:32];
    init_w[13] = hi1_w[31:0];
    init_w[14] = hi1_w[63:32];
    init_w[15] = salsa_pkg::CONST_TE_K;
  end

  // shared adder: quarter-round steps work on fixed slots 0, 4, 8, 12
  always_comb begin
    op_a = x_r[0];
    op_b = init_w[add_r];
    if (st_r == ST_RUN) begin
      case (step_r)
        2'd0:    begin op_a = x_r[0];  op_b = x_r[12]; end
        2'd1:    begin op_a = x_r[4];  op_b = x_r[0];  end
        2'd2:    begin op_a = x_r[8];  op_b = x_r[4];  end
        default: begin op_a = x_r[12]; op_b = x_r[8];  end
      endcase
    end
    sum_w = op_a + op_b;
    case (step_r)
      2'd0:    rot_w = salsa_pkg::rotl32(sum_w, salsa_pkg::ROT_0);
      2'd1:    rot_w = salsa_pkg::rotl32(sum_w, salsa_pkg::ROT_1);
      2'd2:    rot_w = salsa_pkg::rotl32(sum_w, salsa_pkg::ROT_2);
      default: rot_w = salsa_pkg::rotl32(sum_w, salsa_pkg::ROT_3);
    endcase
  end

  // step result, then the fixed slot permutations:
  //   s5 brings the next column quad into slots 0, 4, 8, 12,
  //   s1 undoes the accumulated shift after the fourth quad,
  //   tp transposes so the next column round acts as a row round
  always_comb begin
    logic [3:0] ti;
    for (int i = 0; i < 16; i++) begin
      y_w[i] = x_r[i];
    end
    case (step_r)
      2'd0:    y_w[4]  = x_r[4]  ^ rot_w;
      2'd1:    y_w[8]  = x_r[8]  ^ rot_w;
      2'd2:    y_w[12] = x_r[12] ^ rot_w;
      default: y_w[0]  = x_r[0]  ^ rot_w;
    endcase
    for (int i = 0; i < 16; i++) begin
      s5_w[i] = y_w[4'(i + 5)];
      s1_w[i] = y_w[4'(i + 1)];
    end
    for (int i = 0; i < 16; i++) begin
      ti       = 4'(i);
      tp_w[i]  = s1_w[{ti[1:0], ti[3:2]}];
    end
  end

  // keystream byte
  always_comb begin
    ks_word = emit_blk ? x_nxt[0] : x_r[pos_r[5:2]];
    case (emit_blk ? 2'd0 : pos_r[1:0])
      2'd0:    ks_byte = ks_word[7:0];
      2'd1:    ks_byte = ks_word[15:8];
      2'd2:    ks_byte = ks_word[23:16];
      default: ks_byte = ks_word[31:24];
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    quad_nxt = quad_r;
    rnd_nxt  = rnd_r;
    add_nxt  = add_r;
    for (int i = 0; i < 16; i++) begin
      x_nxt[i] = x_r[i];
    end
    case (st_r)
      ST_IDLE: begin
        if (blk_start) begin
          for (int i = 0; i < 16; i++) begin
            x_nxt[i] = init_w[i];
          end
          step_nxt = 2'd0;
          quad_nxt = 2'd0;
          rnd_nxt  = '0;
          st_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 2'd1;
        if (step_r != STEP_LAST) begin
          for (int i = 0; i < 16; i++) begin
            x_nxt[i] = y_w[i];
          end
        end else if (quad_r != QUAD_LAST) begin
          for (int i = 0; i < 16; i++) begin
            x_nxt[i] = s5_w[i];
          end
          quad_nxt = quad_r + 2'd1;
        end else begin
          for (int i = 0; i < 16; i++) begin
            x_nxt[i] = do_tr ? tp_w[i] : s1_w[i];
          end
          quad_nxt = 2'd0;
          if (last_rnd) begin
            rnd_nxt = '0;
            add_nxt = 4'd0;
            st_nxt  = ST_ADD;
          end else begin
            rnd_nxt = rnd_r + RC_W'(1);
          end
        end
      end
      ST_ADD: begin
        // rotate the words past the adder, feeding forward the input words
        for (int i = 0; i < 15; i++) begin
          x_nxt[i] = x_r[i + 1];
        end
        x_nxt[15] = sum_w;
        add_nxt   = add_r + 4'd1;
        if (add_r == ADD_LAST) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // output register and position
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    pos_nxt       = pos_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (emit_now ? in_tdata : byte_r) ^ ks_byte;
      out_last_nxt  = emit_now ? in_tlast : last_r;
      pos_nxt       = (emit_now ? in_tlast : last_r) ? 32'd0 : pos_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= 2'd0;
      quad_r      <= 2'd0;
      rnd_r       <= '0;
      add_r       <= 4'd0;
      pos_r       <= 32'd0;
      out_valid_r <= 1'b0;
      key0_r      <= 64'd0;
      key1_r      <= 64'd0;
      key2_r      <= 64'd0;
      key3_r      <= 64'd0;
      nonce_r     <= 64'd0;
      mode_r      <= 1'b1;
    end else begin
      st_r        <= st_nxt;
      step_r      <= step_nxt;
      quad_r      <= quad_nxt;
      rnd_r       <= rnd_nxt;
      add_r       <= add_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          salsa_pkg::REG_KEY_0_7:   key0_r  <= cfg_wdata;
          salsa_pkg::REG_KEY_8_15:  key1_r  <= cfg_wdata;
          salsa_pkg::REG_KEY_16_23: key2_r  <= cfg_wdata;
          salsa_pkg::REG_KEY_24_31: key3_r  <= cfg_wdata;
          salsa_pkg::REG_NONCE:     nonce_r <= cfg_wdata;
          salsa_pkg::REG_KEY_MODE:  mode_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      x_r[i] <= x_nxt[i];
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (blk_start) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // the output register is empty for the whole keystream build
  a_out_empty_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN || st_r == ST_ADD) |-> !out_valid_r)
    else $error("output word pending during keystream build");

  // a block start leads to the round phase with a cleared round count
  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    blk_start |=> (st_r == ST_RUN) && (rnd_r == '0) && (step_r == 2'd0))
    else $error("block start did not enter the round phase");

  // a word marked last leaves the position at zero
  a_last_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_last_nxt) |=> (pos_r == 32'd0))
    else $error("position not cleared after last word");

  // round count stays in range while rounds run
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (rnd_r <= LAST_RND))
    else $error("round counter out of range");

endmodule
